// ----- design/led_breath_blink_pwm_driver_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the breathing and blinking LED PWM driver
// Shared shorthand for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef LED_BREATH_BLINK_PWM_DRIVER_MACROS_SVH
`define LED_BREATH_BLINK_PWM_DRIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Invariant that must hold at every edge outside reset.
`define BBP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `BBP_ASSERT_NOW(label, clk, rst, 1'b1, cond, msg)

`endif

// ----- design/bbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbp_pkg
// Types, mode codes, register indexes and the breath table of the LED driver.
// ----------------------------------------------------------------------------
package bbp_pkg;

   localparam int NUM_PINS      = 4;
   localparam int STATUS_PIN    = 3;
   localparam int DUTY_W        = 8;
   localparam int MODE_W        = 3;
   localparam int STATUS_MODE_W = 2;
   localparam int TBL_IDX_W     = 6;
   localparam int TBL_ENTRIES   = 10;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   // Pin mode codes; colour codes above fixed duty behave as off.
   localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BREATH = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIXED  = 3'd4;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_RED_MODE,
      REG_GREEN_MODE,
      REG_BLUE_MODE,
      REG_STATUS_MODE,
      REG_RED_DUTY,
      REG_GREEN_DUTY,
      REG_BLUE_DUTY
   } csr_reg_type;

   localparam logic [DUTY_W-1:0] BREATH_TABLE [TBL_ENTRIES] =
      '{8'd0, 8'd4, 8'd29, 8'd88, 8'd183, 8'd252, 8'd219, 8'd123, 8'd47, 8'd10};

   // Phases beyond the listed entries read a duty of zero.
   function automatic logic [DUTY_W-1:0] breath_at(input logic [TBL_IDX_W-1:0] idx);
      logic [DUTY_W-1:0] duty;
      duty = '0;
      if (idx < TBL_IDX_W'(TBL_ENTRIES)) begin
         duty = BREATH_TABLE[idx[3:0]];
      end
      return duty;
   endfunction

   // Colour mode codes without a meaning fold onto off.
   function automatic logic [MODE_W-1:0] color_mode_eff(input logic [MODE_W-1:0] m);
      logic [MODE_W-1:0] r;
      r = (m > MODE_FIXED) ? MODE_OFF : m;
      return r;
   endfunction

endpackage

// ----- design/led_breath_blink_pwm_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_breath_blink_pwm_driver
// Drives three active-low colour pins and one active-high status pin from a
// PWM counter, with off, on, blink, breath and fixed duty modes per pin.
//
// Channel  Direction  Payload                               Accepted when
// req      in         tdata[0] advance                      req_tvalid & req_tready
// rsp      out        tdata[3:0] pins, tlast period_end     rsp_tvalid & rsp_tready
// csr      in/out     APB, seven registers at 4*i           psel & penable & pwrite
//
// For each request, the state update and the pin levels
// are worked out between the state registers and the result register.
// A new request is taken in every cycle while the result register is empty
// or being emptied; a stalled result holds req_tready low.
// Reset is synchronous and clears the counters, the registers and the
// result valid; the pin latches return to their unlit levels.
// ----------------------------------------------------------------------------
`include "led_breath_blink_pwm_driver_macros.svh"

module led_breath_blink_pwm_driver #(
   parameter int PERIOD_TOP  = 256,
   parameter int STEP_DIVIDE = 40,
   parameter int TABLE_LEN   = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [0] advance
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] red_pin, [1] green_pin, [2] blue_pin, [3] status_pin, [7:4] zero
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,   // period_end
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bbp_pkg::*;

   localparam int PWM_W  = $clog2(PERIOD_TOP + 1);
   localparam int STEP_W = $clog2(STEP_DIVIDE + 1);
   localparam int PH_W   = $clog2(TABLE_LEN);
   localparam int CMP_W  = (PWM_W > DUTY_W) ? PWM_W : DUTY_W;
   localparam int NUM_GROUPS = 2;

   // Configuration registers.
   logic [MODE_W-1:0]        color_mode_ff [3];
   logic [MODE_W-1:0]        color_mode_in [3];
   logic [STATUS_MODE_W-1:0] status_mode_ff, status_mode_in;
   logic [DUTY_W-1:0]        fixed_duty_ff [3];
   logic [DUTY_W-1:0]        fixed_duty_in [3];

   // Animation state; group 0 is colour, group 1 is status.
   logic [PWM_W-1:0]  pwm_count_ff, pwm_count_in;
   logic [STEP_W-1:0] step_ff  [NUM_GROUPS];
   logic [STEP_W-1:0] step_in  [NUM_GROUPS];
   logic [PH_W-1:0]   phase_ff [NUM_GROUPS];
   logic [PH_W-1:0]   phase_in [NUM_GROUPS];
   logic              flag_ff  [NUM_GROUPS];
   logic              flag_in  [NUM_GROUPS];
   logic [DUTY_W-1:0] breath_duty_ff [NUM_GROUPS];
   logic [DUTY_W-1:0] breath_duty_in [NUM_GROUPS];
   logic              pin_latch_ff [NUM_PINS];
   logic              pin_latch_in [NUM_PINS];

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUM_PINS-1:0] rsp_pins_ff, rsp_pins_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                req_accept;
   logic                step_go;
   logic                wrap;
   logic                cfg_write;
   csr_reg_type         cfg_reg;
   logic [1:0]          cfg_pin;
   logic [MODE_W-1:0]   mode_eff [NUM_PINS];
   logic                has_breath [NUM_GROUPS];
   logic                has_blink  [NUM_GROUPS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign step_go    = req_accept && req_tdata[0];
   assign wrap       = pwm_count_ff >= PWM_W'(PERIOD_TOP);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_reg    = csr_reg_type'(csr_paddr[4:2]);
   assign cfg_pin    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   // Effective modes and which groups are animated.
   always_comb begin
      for (int p = 0; p < NUM_PINS; p++) begin
         if (p == STATUS_PIN) begin
            mode_eff[p] = MODE_W'(status_mode_ff);
         end else begin
            mode_eff[p] = color_mode_eff(color_mode_ff[p]);
         end
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         has_breath[g] = 1'b0;
         has_blink[g]  = 1'b0;
      end
      for (int p = 0; p < NUM_PINS; p++) begin
         if (mode_eff[p] == MODE_BREATH) begin
            has_breath[(p == STATUS_PIN) ? 1 : 0] = 1'b1;
         end
         if (mode_eff[p] == MODE_BLINK) begin
            has_blink[(p == STATUS_PIN) ? 1 : 0] = 1'b1;
         end
      end
   end

   // Counter, step dividers, breath table and blink latches.
   always_comb begin
      pwm_count_in = pwm_count_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         step_in[g]        = step_ff[g];
         phase_in[g]       = phase_ff[g];
         flag_in[g]        = flag_ff[g];
         breath_duty_in[g] = breath_duty_ff[g];
      end
      for (int p = 0; p < NUM_PINS; p++) begin
         pin_latch_in[p] = pin_latch_ff[p];
      end

      if (step_go) begin
         if (wrap) begin
            pwm_count_in = '0;
         end else begin
            pwm_count_in = pwm_count_ff + 1'b1;
         end
      end

      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (step_go && wrap && (has_breath[g] || has_blink[g])) begin
            if (step_ff[g] == '0) begin
               if (has_breath[g]) begin
                  breath_duty_in[g] = breath_at(TBL_IDX_W'(phase_ff[g]));
                  if (phase_ff[g] >= PH_W'(TABLE_LEN - 1)) begin
                     phase_in[g] = '0;
                  end else begin
                     phase_in[g] = phase_ff[g] + 1'b1;
                  end
               end
               if (has_blink[g]) begin
                  flag_in[g] = !flag_ff[g];
               end
            end
            if (step_ff[g] >= STEP_W'(STEP_DIVIDE)) begin
               step_in[g] = '0;
            end else begin
               step_in[g] = step_ff[g] + 1'b1;
            end
         end
      end

      // Blink pins take the lit level when the flag is set.
      for (int p = 0; p < NUM_PINS; p++) begin
         if (step_go && wrap && (mode_eff[p] == MODE_BLINK) &&
             (step_ff[(p == STATUS_PIN) ? 1 : 0] == '0)) begin
            pin_latch_in[p] = flag_ff[(p == STATUS_PIN) ? 1 : 0] ?
                              (p == STATUS_PIN) : (p != STATUS_PIN);
         end
      end

      // Register writes; off and on force the latch of the written pin.
      for (int p = 0; p < 3; p++) begin
         color_mode_in[p] = color_mode_ff[p];
         fixed_duty_in[p] = fixed_duty_ff[p];
      end
      status_mode_in = status_mode_ff;
      if (cfg_write) begin
         case (cfg_reg)
            REG_RED_MODE, REG_GREEN_MODE, REG_BLUE_MODE: begin
               color_mode_in[cfg_pin] = csr_pwdata[MODE_W-1:0];
               if (color_mode_eff(csr_pwdata[MODE_W-1:0]) == MODE_OFF) begin
                  pin_latch_in[cfg_pin] = 1'b1;
               end else if (color_mode_eff(csr_pwdata[MODE_W-1:0]) == MODE_ON) begin
                  pin_latch_in[cfg_pin] = 1'b0;
               end
            end
            REG_STATUS_MODE: begin
               status_mode_in = csr_pwdata[STATUS_MODE_W-1:0];
               if (MODE_W'(csr_pwdata[STATUS_MODE_W-1:0]) == MODE_OFF) begin
                  pin_latch_in[STATUS_PIN] = 1'b0;
               end else if (MODE_W'(csr_pwdata[STATUS_MODE_W-1:0]) == MODE_ON) begin
                  pin_latch_in[STATUS_PIN] = 1'b1;
               end
            end
            REG_RED_DUTY:   fixed_duty_in[0] = csr_pwdata[DUTY_W-1:0];
            REG_GREEN_DUTY: fixed_duty_in[1] = csr_pwdata[DUTY_W-1:0];
            REG_BLUE_DUTY:  fixed_duty_in[2] = csr_pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Pin levels after this request, and the result register handshake.
   always_comb begin
      for (int p = 0; p < NUM_PINS; p++) begin
         case (mode_eff[p])
            MODE_BREATH: rsp_pins_in[p] = CMP_W'(pwm_count_in) >=
                            CMP_W'(breath_duty_in[(p == STATUS_PIN) ? 1 : 0]);
            MODE_FIXED:  rsp_pins_in[p] = (p != STATUS_PIN) &&
                            (CMP_W'(pwm_count_in) >= CMP_W'(fixed_duty_ff[p % 3]));
            default:     rsp_pins_in[p] = pin_latch_in[p];
         endcase
      end
      rsp_end_in = step_go && wrap;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Register read-back.
   always_comb begin
      csr_prdata = '0;
      case (cfg_reg)
         REG_RED_MODE:    csr_prdata = CSR_DATA_W'(color_mode_ff[0]);
         REG_GREEN_MODE:  csr_prdata = CSR_DATA_W'(color_mode_ff[1]);
         REG_BLUE_MODE:   csr_prdata = CSR_DATA_W'(color_mode_ff[2]);
         REG_STATUS_MODE: csr_prdata = CSR_DATA_W'(status_mode_ff);
         REG_RED_DUTY:    csr_prdata = CSR_DATA_W'(fixed_duty_ff[0]);
         REG_GREEN_DUTY:  csr_prdata = CSR_DATA_W'(fixed_duty_ff[1]);
         REG_BLUE_DUTY:   csr_prdata = CSR_DATA_W'(fixed_duty_ff[2]);
         default:         csr_prdata = '0;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff   <= '0;
         status_mode_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int p = 0; p < 3; p++) begin
            color_mode_ff[p] <= MODE_OFF;
            fixed_duty_ff[p] <= '0;
         end
         for (int g = 0; g < NUM_GROUPS; g++) begin
            step_ff[g]        <= '0;
            phase_ff[g]       <= '0;
            flag_ff[g]        <= 1'b0;
            breath_duty_ff[g] <= '0;
         end
         for (int p = 0; p < NUM_PINS; p++) begin
            pin_latch_ff[p] <= (p != STATUS_PIN);
         end
      end else begin
         pwm_count_ff   <= pwm_count_in;
         status_mode_ff <= status_mode_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int p = 0; p < 3; p++) begin
            color_mode_ff[p] <= color_mode_in[p];
            fixed_duty_ff[p] <= fixed_duty_in[p];
         end
         for (int g = 0; g < NUM_GROUPS; g++) begin
            step_ff[g]        <= step_in[g];
            phase_ff[g]       <= phase_in[g];
            flag_ff[g]        <= flag_in[g];
            breath_duty_ff[g] <= breath_duty_in[g];
         end
         for (int p = 0; p < NUM_PINS; p++) begin
            pin_latch_ff[p] <= pin_latch_in[p];
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_pins_ff <= rsp_pins_in;
         rsp_end_ff  <= rsp_end_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - NUM_PINS){1'b0}}, rsp_pins_ff};
   assign rsp_tlast  = rsp_end_ff;

   `BBP_ASSERT_ALWAYS(a_pwm_range, clock, reset, pwm_count_ff <= PWM_W'(PERIOD_TOP),
      "PWM counter beyond period top")
   `BBP_ASSERT_ALWAYS(a_phase_range, clock, reset,
      (phase_ff[0] < PH_W'(TABLE_LEN - 1) || phase_ff[0] == PH_W'(TABLE_LEN - 1)) &&
      (phase_ff[1] < PH_W'(TABLE_LEN - 1) || phase_ff[1] == PH_W'(TABLE_LEN - 1)),
      "breath phase beyond table length")
   `BBP_ASSERT_ALWAYS(a_step_range, clock, reset,
      step_ff[0] <= STEP_W'(STEP_DIVIDE) && step_ff[1] <= STEP_W'(STEP_DIVIDE),
      "step divider beyond its top")
   `BBP_ASSERT_NEXT(a_wrap_result, clock, reset, step_go && wrap,
      pwm_count_ff == '0 && rsp_tvalid && rsp_tlast,
      "period end not reported with a wrapped counter")
   `BBP_ASSERT_NEXT(a_hold_without_advance, clock, reset, req_accept && !req_tdata[0],
      pwm_count_ff == $past(pwm_count_ff) && !rsp_tlast,
      "counter moved on a request without advance")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the breathing and blinking LED PWM driver.
// Timer-count requests go in on the req stream while responses are drained
// from the rsp stream. The bench keeps its own pin-level model, which is
// updated on every accepted request and on every register write. Each
// response is compared field by field with the oldest predicted levels.
// Register settings, idle patterns and back-pressure change between phases.
// Runs at full rate carry the counter across period ends so the dividers step.
// ----------------------------------------------------------------------------
module testbench;
   import bbp_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int PWM_TOP      = 256;
   localparam int STEP_DIVIDE  = 40;
   localparam int BREATH_LEN   = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 100;
   localparam int HOLDOFF_LEN  = 300;
   localparam int DRAIN_CYCLES = 8;

   // Levels that one request produces, as seen on the rsp stream.
   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic status;
      logic period_end;
   } led_levels_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [0] advance, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] red_pin, [1] green_pin, [2] blue_pin, [3] status_pin, [7:4] zero
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;   // period_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Pin model state and its copy of the registers.
   logic [2:0] color_mode [3];
   logic [1:0] stat_mode;
   logic [7:0] fixed_duty [3];
   logic [8:0] pwm_count;
   logic [5:0] step_count [2];
   logic [3:0] table_phase [2];
   logic       blink_flag [2];
   logic [7:0] breath_duty [2];
   logic       pin_latch [4];

   led_levels_type expected_levels [$];
   int          error_count    = 0;
   int          report_count   = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          holdoff_token  = 0;
   int          holdoff_seen   = 0;
   int          holdoff_left   = 0;
   int          cycle_count    = 0;

   led_breath_blink_pwm_driver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Pin model
   // ---------------------------------------------------------------------

   // Status is active high, the colour pins are active low.
   function automatic logic lit_level(input int pin);
      return (pin == STATUS_PIN) ? 1'b1 : 1'b0;
   endfunction

   // Colour codes above fixed duty behave as off.
   function automatic logic [2:0] active_mode(input int pin);
      logic [2:0] m;
      if (pin == STATUS_PIN) begin
         m = {1'b0, stat_mode};
      end else if (color_mode[pin] > MODE_FIXED) begin
         m = MODE_OFF;
      end else begin
         m = color_mode[pin];
      end
      return m;
   endfunction

   function automatic logic [7:0] breath_entry(input logic [3:0] phase);
      logic [7:0] duty;
      case (phase)
         4'd0: duty = 8'd0;
         4'd1: duty = 8'd4;
         4'd2: duty = 8'd29;
         4'd3: duty = 8'd88;
         4'd4: duty = 8'd183;
         4'd5: duty = 8'd252;
         4'd6: duty = 8'd219;
         4'd7: duty = 8'd123;
         4'd8: duty = 8'd47;
         4'd9: duty = 8'd10;
         default: duty = 8'd0;
      endcase
      return duty;
   endfunction

   // Step divider of one pin group, run once per PWM wrap.
   function automatic void step_group(input int grp, input int first, input int last);
      logic has_breath;
      logic has_blink;
      int   p;
      has_breath = 1'b0;
      has_blink  = 1'b0;
      for (p = first; p <= last; p++) begin
         if (active_mode(p) == MODE_BREATH) has_breath = 1'b1;
         if (active_mode(p) == MODE_BLINK) has_blink = 1'b1;
      end
      // The divider is frozen while nothing in the group is animated.
      if (!has_breath && !has_blink) return;
      if (step_count[grp] == 6'd0) begin
         if (has_breath) begin
            breath_duty[grp] = breath_entry(table_phase[grp]);
            table_phase[grp] = (table_phase[grp] + 1 >= BREATH_LEN) ?
                               4'd0 : table_phase[grp] + 4'd1;
         end
         if (has_blink) begin
            for (p = first; p <= last; p++) begin
               if (active_mode(p) == MODE_BLINK) begin
                  pin_latch[p] = blink_flag[grp] ? lit_level(p) : !lit_level(p);
               end
            end
            blink_flag[grp] = !blink_flag[grp];
         end
      end
      step_count[grp] = (step_count[grp] >= STEP_DIVIDE) ? 6'd0 : step_count[grp] + 6'd1;
   endfunction

   function automatic logic level_of(input int pin);
      logic [2:0] m;
      m = active_mode(pin);
      if (m == MODE_BREATH) begin
         return pwm_count >= breath_duty[(pin == STATUS_PIN) ? 1 : 0];
      end
      if (m == MODE_FIXED) begin
         return pwm_count >= fixed_duty[pin];
      end
      return pin_latch[pin];
   endfunction

   // Advances the model by one request and returns the levels it produces.
   function automatic led_levels_type predict_led_levels(input logic advance);
      led_levels_type lv;
      lv.period_end = 1'b0;
      if (advance) begin
         if (pwm_count >= PWM_TOP) begin
            lv.period_end = 1'b1;
            pwm_count     = '0;
            step_group(0, 0, 2);
            step_group(1, STATUS_PIN, STATUS_PIN);
         end else begin
            pwm_count = pwm_count + 9'd1;
         end
      end
      lv.red    = level_of(0);
      lv.green  = level_of(1);
      lv.blue   = level_of(2);
      lv.status = level_of(STATUS_PIN);
      return lv;
   endfunction

   // Off and on force the latch; the other modes leave it alone.
   function automatic void force_latch(input int pin);
      if (active_mode(pin) == MODE_OFF) begin
         pin_latch[pin] = !lit_level(pin);
      end else if (active_mode(pin) == MODE_ON) begin
         pin_latch[pin] = lit_level(pin);
      end
   endfunction

   function automatic void apply_register(input csr_reg_type idx, input logic [31:0] value);
      case (idx)
         REG_RED_MODE:    begin color_mode[0] = value[2:0]; force_latch(0); end
         REG_GREEN_MODE:  begin color_mode[1] = value[2:0]; force_latch(1); end
         REG_BLUE_MODE:   begin color_mode[2] = value[2:0]; force_latch(2); end
         REG_STATUS_MODE: begin stat_mode = value[1:0]; force_latch(STATUS_PIN); end
         REG_RED_DUTY:    fixed_duty[0] = value[7:0];
         REG_GREEN_DUTY:  fixed_duty[1] = value[7:0];
         REG_BLUE_DUTY:   fixed_duty[2] = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] register_value(input csr_reg_type idx);
      logic [31:0] v;
      case (idx)
         REG_RED_MODE:    v = {29'd0, color_mode[0]};
         REG_GREEN_MODE:  v = {29'd0, color_mode[1]};
         REG_BLUE_MODE:   v = {29'd0, color_mode[2]};
         REG_STATUS_MODE: v = {30'd0, stat_mode};
         REG_RED_DUTY:    v = {24'd0, fixed_duty[0]};
         REG_GREEN_DUTY:  v = {24'd0, fixed_duty[1]};
         REG_BLUE_DUTY:   v = {24'd0, fixed_duty[2]};
         default:         v = '0;
      endcase
      return v;
   endfunction

   function automatic void reset_model();
      int p;
      for (p = 0; p < 3; p++) begin
         color_mode[p] = MODE_OFF;
         fixed_duty[p] = '0;
      end
      stat_mode = '0;
      pwm_count = '0;
      for (p = 0; p < 2; p++) begin
         step_count[p]  = '0;
         table_phase[p] = '0;
         blink_flag[p]  = 1'b0;
         breath_duty[p] = '0;
      end
      for (p = 0; p < 4; p++) begin
         pin_latch[p] = !lit_level(p);
      end
   endfunction

   function automatic void report_mismatch(input string what, input logic [31:0] want,
                                           input logic [31:0] got);
      error_count++;
      if (report_count < MAX_REPORTS) begin
         report_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response side: checks each response, then decides the next tready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      led_levels_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("response with nothing pending, tlast and tdata", '0,
                            {23'd0, rsp_tlast, rsp_tdata});
         end else begin
            want = expected_levels.pop_front();
            if (rsp_tdata[0] !== want.red) report_mismatch("red_pin", want.red, rsp_tdata[0]);
            if (rsp_tdata[1] !== want.green) begin
               report_mismatch("green_pin", want.green, rsp_tdata[1]);
            end
            if (rsp_tdata[2] !== want.blue) report_mismatch("blue_pin", want.blue, rsp_tdata[2]);
            if (rsp_tdata[3] !== want.status) begin
               report_mismatch("status_pin", want.status, rsp_tdata[3]);
            end
            if (rsp_tlast !== want.period_end) begin
               report_mismatch("period_end", want.period_end, rsp_tlast);
            end
            if (rsp_tdata[7:4] !== 4'h0) report_mismatch("tdata padding", 0, rsp_tdata[7:4]);
         end
      end
      // A new hold-off request starts a long stretch with tready low.
      if (holdoff_token != holdoff_seen) begin
         holdoff_seen = holdoff_token;
         holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request side and register access
   // ---------------------------------------------------------------------

   // Offers one request, after an optional idle gap, and waits for it to be taken.
   task automatic send_request(input logic advance);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, advance};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_levels.push_back(predict_led_levels(advance));
   endtask

   // Stops offering requests and waits for every response; always takes an edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [31:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input csr_reg_type idx);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== register_value(idx)) begin
         report_mismatch($sformatf("register %s read", idx.name()), register_value(idx),
                         csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes every register, half the time with random data, else all zeros or all ones.
   task automatic random_registers();
      int          i;
      logic [31:0] value;
      for (i = 0; i <= int'(REG_BLUE_DUTY); i++) begin
         case ($urandom_range(3))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom();
         endcase
         csr_write(csr_reg_type'(i), value);
      end
   endtask

   task automatic set_modes(input logic [2:0] red, input logic [2:0] green,
                            input logic [2:0] blue, input logic [1:0] status);
      csr_write(REG_RED_MODE, {29'd0, red});
      csr_write(REG_GREEN_MODE, {29'd0, green});
      csr_write(REG_BLUE_MODE, {29'd0, blue});
      csr_write(REG_STATUS_MODE, {30'd0, status});
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // All pins unlit straight after reset, with and without a count.
   task automatic test_reset_levels();
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // Each register written with all ones, random data and zero, then read back.
   task automatic test_register_access();
      int i;
      for (i = 0; i <= int'(REG_BLUE_DUTY); i++) begin
         csr_write(csr_reg_type'(i), 32'hFFFF_FFFF);
         csr_read_check(csr_reg_type'(i));
         csr_write(csr_reg_type'(i), $urandom());
         csr_read_check(csr_reg_type'(i));
         csr_write(csr_reg_type'(i), 32'h0);
         csr_read_check(csr_reg_type'(i));
      end
   endtask

   // Every mode once, unused colour codes, and latch forcing on mode writes.
   task automatic test_mode_basics();
      set_modes(MODE_ON, MODE_OFF, 3'd7, 2'd1);
      send_request(1'b1);
      send_request(1'b0);
      csr_write(REG_RED_DUTY, 32'd0);
      csr_write(REG_GREEN_DUTY, 32'd255);
      csr_write(REG_BLUE_DUTY, 32'd3);
      set_modes(MODE_FIXED, MODE_FIXED, MODE_FIXED, 2'd3);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      // Blink pins keep whatever the latch held before.
      set_modes(MODE_BLINK, MODE_BREATH, 3'd5, 2'd2);
      send_request(1'b1);
      send_request(1'b0);
      set_modes(MODE_OFF, 3'd6, MODE_ON, 2'd0);
      send_request(1'b0);
      set_modes(MODE_ON, MODE_BLINK, MODE_BREATH, 2'd1);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // Random counts under each idle pattern, with new register settings per chunk.
   task automatic test_random_traffic();
      int phase;
      int chunk;
      int n;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         for (chunk = 0; chunk < 2; chunk++) begin
            random_registers();
            for (n = 0; n < 60; n++) begin
               send_request($urandom_range(99) < 85);
            end
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // The receiver holds off while requests keep coming, so the block stalls its
   // input; afterwards the sender waits for every response before going on.
   task automatic test_backpressure();
      int n;
      holdoff_token++;
      for (n = 0; n < 40; n++) begin
         send_request(1'b1);
      end
      wait_drained();
      for (n = 0; n < 20; n++) begin
         send_request($urandom_range(1));
      end
   endtask

   // Runs at full rate that carry the counter across period ends, so dividers
   // step under mixed modes while mode changes freeze and resume each group.
   task automatic test_animation_sweep();
      int seg;
      int n;
      int len;
      for (seg = 0; seg < 5; seg++) begin
         case (seg)
            0: begin
               csr_write(REG_BLUE_DUTY, 32'h80);
               set_modes(MODE_BREATH, MODE_BLINK, MODE_FIXED, 2'd3);
               len = 100;
            end
            1: begin
               set_modes(MODE_ON, MODE_OFF, MODE_ON, 2'd2);
               len = 100;
            end
            2: begin
               set_modes(MODE_BLINK, MODE_BREATH, MODE_BREATH, 2'd0);
               len = 100;
            end
            3: begin
               csr_write(REG_RED_DUTY, 32'hFF);
               set_modes(MODE_FIXED, 3'd5, MODE_BLINK, 2'd2);
               len = 100;
            end
            default: begin
               set_modes(MODE_BREATH, MODE_BREATH, MODE_BREATH, 2'd3);
               len = 100;
            end
         endcase
         for (n = 0; n < len; n++) begin
            send_request($urandom_range(99) < 98);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_levels();
      test_register_access();
      test_mode_basics();
      test_random_traffic();
      test_backpressure();
      test_animation_sweep();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
